// ----- rtl/hdp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdp_pkg
// Shared types, codes and helpers of the HTTP request head parser.
// ----------------------------------------------------------------------------
package hdp_pkg;

   // byte constants
   localparam logic [7:0] CTRL_MAX  = 8'h1F;
   localparam logic [7:0] CASE_STEP = 8'd32;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QMARK  = 8'h3F;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;

   // configuration register indexes
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_METHOD_LIMIT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATH_LIMIT     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_QUERY_LIMIT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PROTOCOL_LIMIT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_LIMIT   = 3'd4;

   // parse stages; header stages count CR/LF bytes in a row
   typedef enum logic [3:0] {
      STG_METHOD   = 4'd0,
      STG_PATH     = 4'd1,
      STG_QUERY    = 4'd2,
      STG_PROTO    = 4'd3,
      STG_PROTO_CR = 4'd4,
      STG_HDR0     = 4'd5,
      STG_HDR1     = 4'd6,
      STG_HDR2     = 4'd7,
      STG_HDR3     = 4'd8,
      STG_BODY     = 4'd9
   } hdp_stage_type;

   typedef enum logic [2:0] {
      SEC_METHOD   = 3'd0,
      SEC_PATH     = 3'd1,
      SEC_QUERY    = 3'd2,
      SEC_PROTOCOL = 3'd3,
      SEC_HEADER   = 3'd4,
      SEC_BODY     = 3'd5,
      SEC_IGNORED  = 3'd6
   } hdp_section_type;

   typedef enum logic [2:0] {
      STATUS_OK  = 3'd0,
      STATUS_400 = 3'd1,
      STATUS_501 = 3'd2,
      STATUS_414 = 3'd3,
      STATUS_505 = 3'd4,
      STATUS_431 = 3'd5
   } hdp_status_type;

   // parser state carried from byte to byte
   typedef struct packed {
      hdp_stage_type  stage;
      logic [15:0]    count;
      logic           hdr_key;
      hdp_status_type verdict;
      logic           err;
   } hdp_state_type;

   localparam hdp_state_type STATE_RESET = '{
      stage:   STG_METHOD,
      count:   16'd0,
      hdr_key: 1'b1,
      verdict: STATUS_OK,
      err:     1'b0
   };

   // section length limits
   typedef struct packed {
      logic [7:0]  method;
      logic [15:0] path;
      logic [15:0] query;
      logic [7:0]  protocol;
      logic [15:0] header;
   } hdp_limits_type;

   // one result transaction
   typedef struct packed {
      logic [7:0]      out_byte;
      hdp_section_type section;
      logic            counted;
      logic            error_seen;
      hdp_status_type  status;
      logic            last;
   } hdp_result_type;

   // a zero limit behaves as one
   function automatic logic [15:0] hdp_eff_limit(input logic [15:0] lim);
      return (lim == 16'd0) ? 16'd1 : lim;
   endfunction

   // lower-case A-Z only
   function automatic logic [7:0] hdp_to_lower(input logic [7:0] b);
      return (b >= CH_UPPER_A && b <= CH_UPPER_Z) ? b + CASE_STEP : b;
   endfunction

endpackage

// ----- rtl/hdp_csr.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdp_csr
// Limit registers of the parser, written through a valid/ready port.
// ----------------------------------------------------------------------------
module hdp_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [hdp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [hdp_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output hdp_pkg::hdp_limits_type         limits
);
   import hdp_pkg::*;

   hdp_limits_type limits_ff;
   hdp_limits_type limits_in;

   // always able to take a write
   assign csr_ready = 1'b1;

   // register decode, unknown indexes are dropped
   always_comb begin
      limits_in = limits_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_METHOD_LIMIT:   limits_in.method   = csr_wdata[7:0];
            CSR_PATH_LIMIT:     limits_in.path     = csr_wdata;
            CSR_QUERY_LIMIT:    limits_in.query    = csr_wdata;
            CSR_PROTOCOL_LIMIT: limits_in.protocol = csr_wdata[7:0];
            CSR_HEADER_LIMIT:   limits_in.header   = csr_wdata;
            default:            limits_in = limits_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.method   <= 8'd8;
         limits_ff.path     <= 16'd128;
         limits_ff.query    <= 16'd256;
         limits_ff.protocol <= 8'd16;
         limits_ff.header   <= 16'd2048;
      end else begin
         limits_ff <= limits_in;
      end
   end

   assign limits = limits_ff;

endmodule

// ----- rtl/hdp_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdp_step
// Per-byte classification: next parser state and the result transaction.
// ----------------------------------------------------------------------------
module hdp_step (
   input  hdp_pkg::hdp_state_type   cur,
   input  hdp_pkg::hdp_limits_type  limits,
   input  logic [7:0]               in_byte,
   input  logic                     in_last,
   output hdp_pkg::hdp_state_type   nxt,
   output hdp_pkg::hdp_result_type  res
);
   import hdp_pkg::*;

   logic [15:0]    cnt_inc;
   logic [7:0]     lower;
   logic           ctrl;
   logic           delim;
   logic           err_hit;
   hdp_status_type err_code;
   hdp_stage_type  hdr_inc;
   hdp_state_type  upd;

   assign cnt_inc = cur.count + 16'd1;
   assign lower   = hdp_to_lower(in_byte);
   assign ctrl    = (in_byte <= CTRL_MAX);
   assign delim   = (in_byte == CH_CR) || (in_byte == CH_LF);

   // header stage after one more CR/LF byte
   always_comb begin
      unique case (cur.stage)
         STG_HDR0: hdr_inc = STG_HDR1;
         STG_HDR1: hdr_inc = STG_HDR2;
         STG_HDR2: hdr_inc = STG_HDR3;
         default:  hdr_inc = STG_BODY;
      endcase
   end

   always_comb begin
      upd          = cur;
      err_hit      = 1'b0;
      err_code     = STATUS_OK;
      res.out_byte = in_byte;
      res.section  = SEC_IGNORED;
      res.counted  = 1'b0;

      if (!cur.err) begin
         // stage work
         unique case (cur.stage)
            STG_METHOD: begin
               res.out_byte = lower;
               res.section  = SEC_METHOD;
               if (in_byte == CH_SPACE) begin
                  if (cur.count == 16'd0) begin
                     err_hit  = 1'b1;
                     err_code = STATUS_501;
                  end else begin
                     upd.stage = STG_PATH;
                     upd.count = 16'd0;
                  end
               end else if (ctrl) begin
                  err_hit  = 1'b1;
                  err_code = STATUS_400;
               end else begin
                  res.counted = 1'b1;
                  upd.count   = cnt_inc;
                  if (cnt_inc >= hdp_eff_limit({8'd0, limits.method})) begin
                     err_hit  = 1'b1;
                     err_code = STATUS_501;
                  end
               end
            end
            STG_PATH: begin
               res.section = SEC_PATH;
               if (in_byte == CH_QMARK || in_byte == CH_SPACE) begin
                  if (cur.count == 16'd0) begin
                     err_hit  = 1'b1;
                     err_code = STATUS_414;
                  end else begin
                     upd.stage = (in_byte == CH_QMARK) ? STG_QUERY : STG_PROTO;
                     upd.count = 16'd0;
                  end
               end else if (ctrl) begin
                  err_hit  = 1'b1;
                  err_code = STATUS_400;
               end else begin
                  res.counted = 1'b1;
                  upd.count   = cnt_inc;
                  if (cnt_inc >= hdp_eff_limit(limits.path)) begin
                     err_hit  = 1'b1;
                     err_code = STATUS_414;
                  end
               end
            end
            STG_QUERY: begin
               res.section = SEC_QUERY;
               if (in_byte == CH_SPACE) begin
                  upd.stage = STG_PROTO;
                  upd.count = 16'd0;
               end else if (ctrl) begin
                  err_hit  = 1'b1;
                  err_code = STATUS_400;
               end else begin
                  res.counted = 1'b1;
                  upd.count   = cnt_inc;
                  if (cnt_inc >= hdp_eff_limit(limits.query)) begin
                     err_hit  = 1'b1;
                     err_code = STATUS_414;
                  end
               end
            end
            STG_PROTO, STG_PROTO_CR: begin
               res.out_byte = lower;
               res.section  = SEC_PROTOCOL;
               if (in_byte == CH_CR) begin
                  upd.stage = STG_PROTO_CR;
               end else if (in_byte == CH_LF) begin
                  if (cur.count == 16'd0) begin
                     err_hit  = 1'b1;
                     err_code = STATUS_505;
                  end else begin
                     upd.stage   = STG_HDR2;
                     upd.count   = 16'd0;
                     upd.hdr_key = 1'b1;
                  end
               end else if (ctrl) begin
                  err_hit  = 1'b1;
                  err_code = STATUS_400;
               end else begin
                  res.counted = 1'b1;
                  upd.count   = cnt_inc;
                  if (cnt_inc >= hdp_eff_limit({8'd0, limits.protocol})) begin
                     err_hit  = 1'b1;
                     err_code = (cur.stage == STG_PROTO) ? STATUS_505 : STATUS_400;
                  end
               end
            end
            STG_HDR0, STG_HDR1, STG_HDR2, STG_HDR3: begin
               res.section = SEC_HEADER;
               if (cur.hdr_key) begin
                  res.out_byte = lower;
               end
               if (in_byte == CH_COLON) begin
                  upd.hdr_key = 1'b0;
               end
               if (delim) begin
                  upd.hdr_key = 1'b1;
                  upd.stage   = hdr_inc;
               end else if (ctrl) begin
                  err_hit  = 1'b1;
                  err_code = STATUS_400;
               end else begin
                  upd.stage = STG_HDR0;
               end
               // header budget, CR and LF included
               if (!err_hit) begin
                  res.counted = 1'b1;
                  upd.count   = cnt_inc;
                  if (upd.stage == STG_BODY) begin
                     upd.count = 16'd0;
                  end else if (cnt_inc >= hdp_eff_limit(limits.header)) begin
                     err_hit  = 1'b1;
                     err_code = (upd.stage == STG_HDR3) ? STATUS_400 : STATUS_431;
                  end
               end
            end
            default: begin
               res.section = SEC_BODY;
               res.counted = 1'b1;
            end
         endcase

         // incomplete head on the final byte
         if (!err_hit && in_last) begin
            unique case (upd.stage)
               STG_METHOD: begin
                  err_hit  = 1'b1;
                  err_code = STATUS_501;
               end
               STG_PATH, STG_QUERY: begin
                  err_hit  = 1'b1;
                  err_code = STATUS_414;
               end
               STG_PROTO: begin
                  err_hit  = 1'b1;
                  err_code = STATUS_505;
               end
               STG_PROTO_CR: begin
                  err_hit  = 1'b1;
                  err_code = (upd.count == 16'd0) ? STATUS_505 : STATUS_400;
               end
               STG_HDR0, STG_HDR1, STG_HDR2: begin
                  err_hit  = 1'b1;
                  err_code = STATUS_431;
               end
               STG_HDR3: begin
                  err_hit  = 1'b1;
                  err_code = STATUS_400;
               end
               default: begin
                  err_hit = 1'b0;
               end
            endcase
         end

         // latch the verdict
         if (err_hit) begin
            upd.verdict = err_code;
            upd.err     = 1'b1;
         end
      end

      res.error_seen = upd.err;
      res.status     = upd.verdict;
      res.last       = in_last;

      // ready for the next buffer after the final byte
      nxt = in_last ? STATE_RESET : upd;
   end

endmodule

// ----- rtl/http_request_head_parser.sv -----
`timescale 1ns / 1ps
// An accepted byte is held in the input register; its result moves on to the
// result register when that is empty or the result side does not stall. One
// byte per cycle while rsp_stall is low, set by the state update between them.
// reset: synchronous, clears parser state and the valid bits of both
// pipeline registers and loads the default limits
// ----------------------------------------------------------------------------
// http_request_head_parser
// Byte-wide HTTP request head parser with section tagging, lower-casing
// of method, protocol and header keys, and length limit checks.
// ----------------------------------------------------------------------------
module http_request_head_parser (
   input  logic                            clock,
   input  logic                            reset,
   // input channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_in_byte,
   input  logic                            req_end_of_buffer,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [7:0]                      rsp_out_byte,
   output logic [2:0]                      rsp_section,
   output logic                            rsp_counted,
   output logic                            rsp_error_seen,
   output logic [2:0]                      rsp_status,
   output logic                            rsp_last,
   // configuration port
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [hdp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [hdp_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import hdp_pkg::*;

   hdp_limits_type limits;
   hdp_state_type  state_ff;
   hdp_state_type  state_in;
   hdp_result_type res_in;
   hdp_result_type res_ff;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       out_valid_ff;
   logic       advance;

   // limit registers
   hdp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .limits    (limits)
   );

   // per-byte logic
   hdp_step u_step (
      .cur      (state_ff),
      .limits   (limits),
      .in_byte  (in_byte_ff),
      .in_last  (in_last_ff),
      .nxt      (state_in),
      .res      (res_in)
   );

   // move a byte from input register to result register
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   // valid bits and parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_byte_ff <= req_in_byte;
         in_last_ff <= req_end_of_buffer;
      end
      if (advance) begin
         res_ff <= res_in;
      end
   end

   // result transaction
   assign rsp_valid      = out_valid_ff;
   assign rsp_out_byte   = res_ff.out_byte;
   assign rsp_section    = res_ff.section;
   assign rsp_counted    = res_ff.counted;
   assign rsp_error_seen = res_ff.error_seen;
   assign rsp_status     = res_ff.status;
   assign rsp_last       = res_ff.last;

endmodule

// ----- tb/sv/tb_http_request_head_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_http_request_head_parser
// Self-checking bench for the HTTP request head parser. Request buffers are
// fed one byte per transaction. A byte-level model of the parser predicts
// every result transaction, including section tags, lower-casing, length
// limits and error verdicts. Covers directed corner cases, tight and wide
// limit settings, random traffic with random idling on both sides, and a
// long result-side hold.
// ----------------------------------------------------------------------------
module tb_http_request_head_parser;
   import hdp_pkg::*;

   localparam int CLK_PERIOD   = 10;
   localparam int DRAIN_CYCLES = 6;
   localparam int WATCHDOG_NS  = 2_000_000;
   localparam int MAX_REPORTS  = 10;
   localparam int HOLD_CYCLES  = 300;

   localparam hdp_limits_type LIMITS_AT_RESET = '{
      method:   8'd8,
      path:     16'd128,
      query:    16'd256,
      protocol: 8'd16,
      header:   16'd2048
   };

   typedef enum int {
      LIMITS_DEFAULT,
      LIMITS_TIGHT,
      LIMITS_WIDEST
   } limit_plan_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [7:0]            req_in_byte;
   logic                  req_end_of_buffer;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [7:0]            rsp_out_byte;
   logic [2:0]            rsp_section;
   logic                  rsp_counted;
   logic                  rsp_error_seen;
   logic [2:0]            rsp_status;
   logic                  rsp_last;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // traffic shaping
   int req_idle_pct;
   int rsp_idle_pct;
   int hold_request;

   // limits as currently programmed, used by the request generator
   hdp_limits_type cur_limits = LIMITS_AT_RESET;

   // bytes of the buffer under construction
   logic [7:0] head_bytes[$];

   // predicted result transactions, oldest first
   hdp_result_type pending_results[$];

   // parser model state
   hdp_limits_type lim_model = LIMITS_AT_RESET;
   hdp_stage_type  stage_model;
   logic [15:0]    count_model;
   logic           key_model;
   hdp_status_type verdict_model;
   logic           err_model;

   // run statistics
   int mismatches      = 0;
   int bytes_seen      = 0;
   int buffers_seen    = 0;
   int errored_buffers = 0;
   int body_bytes      = 0;

   http_request_head_parser i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_end_of_buffer (req_end_of_buffer),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_section       (rsp_section),
      .rsp_counted       (rsp_counted),
      .rsp_error_seen    (rsp_error_seen),
      .rsp_status        (rsp_status),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // watchdog
   initial begin
      #(WATCHDOG_NS);
      $display("Verification failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // parser model
   // ---------------------------------------------------------------------

   function automatic logic [7:0] fold_case(input logic [7:0] b);
      return (b >= CH_UPPER_A && b <= CH_UPPER_Z) ? b + CASE_STEP : b;
   endfunction

   // a limit of zero behaves as one
   function automatic logic [15:0] floor_one(input logic [15:0] lim);
      return (lim == 16'd0) ? 16'd1 : lim;
   endfunction

   function automatic void clear_parse_model();
      stage_model   = STG_METHOD;
      count_model   = 16'd0;
      key_model     = 1'b1;
      verdict_model = STATUS_OK;
      err_model     = 1'b0;
   endfunction

   // advance the model by one byte and return its result transaction
   function automatic hdp_result_type parse_byte(input logic [7:0] b, input logic eob);
      hdp_result_type r;
      logic           found;
      hdp_status_type code;
      logic           is_delim;
      r.out_byte = b;
      r.section  = SEC_IGNORED;
      r.counted  = 1'b0;
      found      = 1'b0;
      code       = STATUS_OK;
      if (!err_model) begin
         case (stage_model)
            STG_METHOD: begin
               r.out_byte = fold_case(b);
               r.section  = SEC_METHOD;
               if (r.out_byte == CH_SPACE) begin
                  if (count_model == 16'd0) begin
                     found = 1'b1;
                     code  = STATUS_501;
                  end else begin
                     stage_model = STG_PATH;
                     count_model = 16'd0;
                  end
               end else if (r.out_byte <= CTRL_MAX) begin
                  found = 1'b1;
                  code  = STATUS_400;
               end else begin
                  r.counted   = 1'b1;
                  count_model = count_model + 16'd1;
                  if (count_model >= floor_one({8'd0, lim_model.method})) begin
                     found = 1'b1;
                     code  = STATUS_501;
                  end
               end
            end
            STG_PATH: begin
               r.section = SEC_PATH;
               if (b == CH_QMARK || b == CH_SPACE) begin
                  if (count_model == 16'd0) begin
                     found = 1'b1;
                     code  = STATUS_414;
                  end else begin
                     stage_model = (b == CH_QMARK) ? STG_QUERY : STG_PROTO;
                     count_model = 16'd0;
                  end
               end else if (b <= CTRL_MAX) begin
                  found = 1'b1;
                  code  = STATUS_400;
               end else begin
                  r.counted   = 1'b1;
                  count_model = count_model + 16'd1;
                  if (count_model >= floor_one(lim_model.path)) begin
                     found = 1'b1;
                     code  = STATUS_414;
                  end
               end
            end
            STG_QUERY: begin
               r.section = SEC_QUERY;
               if (b == CH_SPACE) begin
                  stage_model = STG_PROTO;
                  count_model = 16'd0;
               end else if (b <= CTRL_MAX) begin
                  found = 1'b1;
                  code  = STATUS_400;
               end else begin
                  r.counted   = 1'b1;
                  count_model = count_model + 16'd1;
                  if (count_model >= floor_one(lim_model.query)) begin
                     found = 1'b1;
                     code  = STATUS_414;
                  end
               end
            end
            STG_PROTO, STG_PROTO_CR: begin
               r.out_byte = fold_case(b);
               r.section  = SEC_PROTOCOL;
               if (b == CH_CR) begin
                  stage_model = STG_PROTO_CR;
               end else if (b == CH_LF) begin
                  if (count_model == 16'd0) begin
                     found = 1'b1;
                     code  = STATUS_505;
                  end else begin
                     stage_model = STG_HDR2;
                     count_model = 16'd0;
                     key_model   = 1'b1;
                  end
               end else if (b <= CTRL_MAX) begin
                  found = 1'b1;
                  code  = STATUS_400;
               end else begin
                  r.counted   = 1'b1;
                  count_model = count_model + 16'd1;
                  if (count_model >= floor_one({8'd0, lim_model.protocol})) begin
                     found = 1'b1;
                     code  = (stage_model == STG_PROTO) ? STATUS_505 : STATUS_400;
                  end
               end
            end
            STG_HDR0, STG_HDR1, STG_HDR2, STG_HDR3: begin
               r.section = SEC_HEADER;
               if (key_model) r.out_byte = fold_case(b);
               if (b == CH_COLON) key_model = 1'b0;
               is_delim = (b == CH_CR || b == CH_LF);
               if (is_delim) begin
                  key_model   = 1'b1;
                  stage_model = hdp_stage_type'(stage_model + 4'd1);
               end else if (b <= CTRL_MAX) begin
                  found = 1'b1;
                  code  = STATUS_400;
               end else begin
                  stage_model = STG_HDR0;
               end
               if (!found) begin
                  r.counted   = 1'b1;
                  count_model = count_model + 16'd1;
                  // the byte that closes the head is never over budget
                  if (stage_model == STG_BODY) begin
                     count_model = 16'd0;
                  end else if (count_model >= floor_one(lim_model.header)) begin
                     found = 1'b1;
                     code  = (stage_model == STG_HDR3) ? STATUS_400 : STATUS_431;
                  end
               end
            end
            default: begin
               r.section = SEC_BODY;
               r.counted = 1'b1;
            end
         endcase

         // head cut short by the end of the buffer
         if (!found && eob) begin
            found = 1'b1;
            case (stage_model)
               STG_METHOD:                   code = STATUS_501;
               STG_PATH, STG_QUERY:          code = STATUS_414;
               STG_PROTO:                    code = STATUS_505;
               STG_PROTO_CR:
                  code = (count_model == 16'd0) ? STATUS_505 : STATUS_400;
               STG_HDR0, STG_HDR1, STG_HDR2: code = STATUS_431;
               STG_HDR3:                     code = STATUS_400;
               default:                      found = 1'b0;
            endcase
         end
         if (found) begin
            verdict_model = code;
            err_model     = 1'b1;
         end
      end
      r.error_seen = err_model;
      r.status     = verdict_model;
      r.last       = eob;
      if (eob) clear_parse_model();
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // monitor: register writes, byte transactions and result checks
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      hdp_result_type got;
      hdp_result_type want;
      if (reset) begin
         clear_parse_model();
         lim_model = LIMITS_AT_RESET;
         pending_results.delete();
      end else begin
         // register write
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_METHOD_LIMIT:   lim_model.method   = csr_wdata[7:0];
               CSR_PATH_LIMIT:     lim_model.path     = csr_wdata;
               CSR_QUERY_LIMIT:    lim_model.query    = csr_wdata;
               CSR_PROTOCOL_LIMIT: lim_model.protocol = csr_wdata[7:0];
               CSR_HEADER_LIMIT:   lim_model.header   = csr_wdata;
               default: ;
            endcase
         end

         // accepted byte
         if (req_valid && !req_stall)
            pending_results.push_back(parse_byte(req_in_byte, req_end_of_buffer));

         // accepted result
         if (rsp_valid && !rsp_stall) begin
            got.out_byte   = rsp_out_byte;
            got.section    = hdp_section_type'(rsp_section);
            got.counted    = rsp_counted;
            got.error_seen = rsp_error_seen;
            got.status     = hdp_status_type'(rsp_status);
            got.last       = rsp_last;
            bytes_seen++;
            if (got.section == SEC_BODY) body_bytes++;
            if (got.last) begin
               buffers_seen++;
               if (got.error_seen) errored_buffers++;
            end
            if (pending_results.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("[%0t] result with nothing pending: byte %h section %0d status %0d",
                           $time, got.out_byte, got.section, got.status);
            end else begin
               want = pending_results.pop_front();
               if (got.out_byte !== want.out_byte || got.section !== want.section ||
                   got.counted !== want.counted || got.error_seen !== want.error_seen ||
                   got.status !== want.status || got.last !== want.last) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS) begin
                     $display("[%0t] mismatch byte/section/counted/error/status/last:",
                              $time);
                     $display("   expected %h %0d %b %b %0d %b, got %h %0d %b %b %0d %b",
                              want.out_byte, want.section, want.counted,
                              want.error_seen, want.status, want.last,
                              got.out_byte, got.section, got.counted,
                              got.error_seen, got.status, got.last);
                  end
               end
            end
         end
      end
   end

   // result side: random stall, or a long hold when one is requested
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   // ---------------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------------

   // one byte transaction, after an optional random gap
   task automatic send_byte(input logic [7:0] b, input logic eob);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_in_byte       <= b;
      req_end_of_buffer <= eob;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   // send the assembled buffer, marking its final byte
   task automatic send_buffer();
      foreach (head_bytes[i]) send_byte(head_bytes[i], i == head_bytes.size() - 1);
      head_bytes.delete();
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) head_bytes.push_back(s[i]);
   endtask

   // stop offering bytes and wait for every result to come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
   endtask

   // program all five limits while the parser is idle
   task automatic set_limits(input logic [15:0] m, input logic [15:0] p, input logic [15:0] q,
                             input logic [15:0] pr, input logic [15:0] h);
      wait_idle();
      write_reg(CSR_METHOD_LIMIT, m);
      write_reg(CSR_PATH_LIMIT, p);
      write_reg(CSR_QUERY_LIMIT, q);
      write_reg(CSR_PROTOCOL_LIMIT, pr);
      write_reg(CSR_HEADER_LIMIT, h);
      csr_valid <= 1'b0;
      @(posedge clock);
      cur_limits = '{method: m[7:0], path: p, query: q, protocol: pr[7:0], header: h};
   endtask

   // ---------------------------------------------------------------------
   // request generator
   // ---------------------------------------------------------------------

   function automatic logic [7:0] rand_letter();
      logic [7:0] base;
      base = $urandom_range(1) ? CH_UPPER_A : CH_UPPER_A + CASE_STEP;
      return base + 8'($urandom_range(25));
   endfunction

   function automatic logic [7:0] rand_path_char();
      logic [7:0] c;
      do c = 8'($urandom_range(8'hFF, 8'h21)); while (c == CH_QMARK);
      return c;
   endfunction

   // section length: mostly short, now and then around the limit (limits up to 40)
   function automatic int pick_len(input int lim);
      int e;
      int top;
      e = (lim == 0) ? 1 : lim;
      if (e <= 40 && $urandom_range(7) == 0) return e - 1 + int'($urandom_range(2));
      top = (e > 12) ? 11 : ((e > 1) ? e - 1 : 1);
      return int'($urandom_range(top, 1));
   endfunction

   // line end: usually CR LF, sometimes a bare LF
   task automatic push_eol();
      if ($urandom_range(4) != 0) head_bytes.push_back(CH_CR);
      head_bytes.push_back(CH_LF);
   endtask

   // random request head, at times reaching a limit, then a short body
   task automatic build_request();
      int n;
      int nh;
      n = pick_len(cur_limits.method);
      repeat (n)
         head_bytes.push_back($urandom_range(4) ? rand_letter() : 8'($urandom_range(255, 33)));
      head_bytes.push_back(CH_SPACE);
      n = pick_len(cur_limits.path);
      repeat (n) head_bytes.push_back(rand_path_char());
      if ($urandom_range(2) == 0) begin
         head_bytes.push_back(CH_QMARK);
         n = pick_len(cur_limits.query);
         repeat (n) head_bytes.push_back(8'($urandom_range(8'hFF, 8'h21)));
      end
      head_bytes.push_back(CH_SPACE);
      if (cur_limits.protocol > 8'd8 && $urandom_range(1)) begin
         push_text("HTTP/1.1");
      end else begin
         n = pick_len(cur_limits.protocol);
         repeat (n) head_bytes.push_back($urandom_range(3) ? rand_letter() : "/");
      end
      // text between CR and LF of the request line
      if ($urandom_range(9) == 0) begin
         head_bytes.push_back(CH_CR);
         head_bytes.push_back(rand_letter());
      end
      push_eol();
      nh = $urandom_range(3);
      repeat (nh) begin
         repeat ($urandom_range(8, 1))
            head_bytes.push_back($urandom_range(5) ? rand_letter() : "-");
         head_bytes.push_back(CH_COLON);
         if ($urandom_range(1)) head_bytes.push_back(CH_SPACE);
         repeat ($urandom_range(12)) head_bytes.push_back(8'($urandom_range(8'hFF, 8'h20)));
         push_eol();
      end
      push_eol();
      repeat ($urandom_range(6)) head_bytes.push_back(8'($urandom_range(255)));
   endtask

   // noise, a truncated head, a corrupted head or a clean one
   task automatic build_mixed_buffer();
      int pick;
      int keep;
      int idx;
      pick = $urandom_range(99);
      if (pick < 10) begin
         repeat ($urandom_range(8, 1)) head_bytes.push_back(8'($urandom_range(255)));
      end else begin
         build_request();
         if (pick < 25) begin
            keep = $urandom_range(head_bytes.size(), 1);
            while (head_bytes.size() > keep) void'(head_bytes.pop_back());
         end else if (pick < 35) begin
            idx = $urandom_range(head_bytes.size() - 1);
            case ($urandom_range(3))
               0: head_bytes[idx] = 8'($urandom_range(CTRL_MAX));
               1: head_bytes[idx] = CH_SPACE;
               2: head_bytes[idx] = CH_QMARK;
               default: head_bytes[idx] = CH_COLON;
            endcase
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // corner cases at the reset limits
   task automatic test_directed_cases();
      // minimal complete head with CR after the protocol, then a body byte
      push_text("A / H");
      head_bytes.push_back(CH_CR);
      head_bytes.push_back(CH_LF);
      head_bytes.push_back(CH_CR);
      head_bytes.push_back(CH_LF);
      push_text("Z");
      send_buffer();
      // empty method
      push_text(" ");
      send_buffer();
      // empty path
      push_text("G ?");
      send_buffer();
      // control byte in the path, then an ignored byte
      push_text("G /");
      head_bytes.push_back(CTRL_MAX);
      head_bytes.push_back(8'h00);
      send_buffer();
      // empty protocol
      push_text("G / ");
      head_bytes.push_back(CH_LF);
      send_buffer();
      // buffer ends inside the method on a high byte
      head_bytes.push_back(8'hFF);
      send_buffer();
   endtask

   // each limit reached on its first counted byte, zero and oversized writes
   task automatic test_limit_edges();
      set_limits(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
      push_text("GET");
      send_buffer();
      set_limits(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      push_text("AB");
      send_buffer();
      set_limits(16'd2, 16'd1, 16'd1, 16'd1, 16'd1);
      push_text("A /x");
      send_buffer();
      set_limits(16'd2, 16'd2, 16'd1, 16'd1, 16'd1);
      push_text("A /?q");
      send_buffer();
      set_limits(16'd2, 16'd2, 16'd2, 16'd1, 16'd1);
      push_text("A / H");
      send_buffer();
      push_text("A / ");
      head_bytes.push_back(CH_CR);
      push_text("X");
      send_buffer();
      set_limits(16'd2, 16'd2, 16'd2, 16'd16, 16'd1);
      push_text("A / H");
      head_bytes.push_back(CH_LF);
      push_text("K");
      send_buffer();
      push_text("A / H");
      head_bytes.push_back(CH_LF);
      head_bytes.push_back(CH_CR);
      send_buffer();
      set_limits(16'd2, 16'd2, 16'd2, 16'd16, 16'd2);
      push_text("A / H");
      head_bytes.push_back(CH_LF);
      head_bytes.push_back(CH_CR);
      head_bytes.push_back(CH_LF);
      push_text("B");
      send_buffer();
      // bits above the register width are dropped
      set_limits(16'h01FF, 16'hFFFF, 16'hFFFF, 16'h0FFF, 16'hFFFF);
      push_text("Ab / x");
      head_bytes.push_back(CH_CR);
      head_bytes.push_back(CH_LF);
      send_buffer();
   endtask

   // random buffers under one idling pattern and limit plan
   task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                      input int n_items, input limit_plan_type plan);
      int sent;
      int chunk_left;
      sent       = 0;
      chunk_left = 0;
      case (plan)
         LIMITS_DEFAULT: set_limits(16'd8, 16'd128, 16'd256, 16'd16, 16'd2048);
         LIMITS_WIDEST:  set_limits(16'd255, 16'hFFFF, 16'hFFFF, 16'd255, 16'hFFFF);
         default: ;
      endcase
      req_idle_pct = send_pct;
      rsp_idle_pct = recv_pct;
      while (sent < n_items) begin
         // tight limits are redrawn every so often
         if (plan == LIMITS_TIGHT && chunk_left <= 0) begin
            set_limits(16'($urandom_range(10, 1)), 16'($urandom_range(24, 1)),
                       16'($urandom_range(24, 1)), 16'($urandom_range(12, 1)),
                       16'($urandom_range(60, 1)));
            chunk_left = 150;
         end
         build_mixed_buffer();
         sent       += head_bytes.size();
         chunk_left -= head_bytes.size();
         send_buffer();
      end
   endtask

   // result side held off while bytes keep coming, so the input backs up
   task automatic test_stall_pressure();
      set_limits(16'd8, 16'd128, 16'd256, 16'd16, 16'd2048);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_request = HOLD_CYCLES;
      repeat (3) begin
         build_request();
         send_buffer();
      end
   endtask

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_in_byte       = 8'd0;
      req_end_of_buffer = 1'b0;
      csr_valid         = 1'b0;
      csr_index         = CSR_METHOD_LIMIT;
      csr_wdata         = 16'd0;
      req_idle_pct      = 0;
      rsp_idle_pct      = 0;
      hold_request      = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_limit_edges();
      test_random_traffic(27, 52, 520, LIMITS_DEFAULT);
      test_random_traffic(52, 27, 520, LIMITS_TIGHT);
      test_random_traffic(0, 0, 520, LIMITS_WIDEST);
      test_stall_pressure();
      wait_idle();

      $display("checked %0d bytes in %0d buffers: %0d closed with an error status, %0d body bytes",
               bytes_seen, buffers_seen, errored_buffers, body_bytes);
      $display("limits: reset values, zero and one, tight random, widest; hold of %0d cycles",
               HOLD_CYCLES);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("Verification failed");
      end
      $finish;
   end

endmodule
